### hdl/assert_macros.svh
// Assertion macros for the checker file of the parameter access engine.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, inactive while reset is asserted (active-low reset).
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/cpae_pkg.sv
// Package of the CAN parameter access engine: codes, types and helper functions.
// No dependencies; used by every module of the block except cpae_ram.
`timescale 1ns / 1ps
`default_nettype none
package cpae_pkg;

    localparam int NUM_PARAMS_DEF = 32;
    localparam int MAX_GROUPS     = 6;
    localparam int IDX_W          = 6;   // entry index width, covers up to 64 entries

    // command byte codes
    localparam logic [7:0] CMD_INIT    = 8'h01;
    localparam logic [7:0] CMD_INJECT  = 8'h02;
    localparam logic [7:0] CMD_REQUEST = 8'h03;

    // response kinds
    localparam logic [1:0] KIND_EMPTY = 2'd0;
    localparam logic [1:0] KIND_DIAG  = 2'd1;
    localparam logic [1:0] KIND_ACK   = 2'd2;
    localparam logic [1:0] KIND_VALUE = 2'd3;

    // entry type codes
    localparam logic [2:0] TYPE_FLAG = 3'd0;
    localparam logic [2:0] TYPE_U8   = 3'd1;
    localparam logic [2:0] TYPE_U16  = 3'd2;
    localparam logic [2:0] TYPE_U32  = 3'd3;
    localparam logic [2:0] TYPE_S8   = 3'd4;
    localparam logic [2:0] TYPE_S16  = 3'd5;
    localparam logic [2:0] TYPE_S32  = 3'd6;
    localparam logic [2:0] TYPE_RAW  = 3'd7;

    // configuration register indexes
    localparam logic [2:0] CFG_GROUP_COUNT = 3'd0;
    localparam logic [2:0] CFG_GROUP_ENDS  = 3'd1;
    localparam logic [2:0] CFG_PARAM_TOTAL = 3'd2;
    localparam logic [2:0] CFG_TYPE_LO     = 3'd3;
    localparam logic [2:0] CFG_TYPE_HI     = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    typedef enum logic [1:0] {
        LINK_DISC  = 2'd0,
        LINK_DIAG  = 2'd1,
        LINK_READY = 2'd2
    } t_link;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } t_ctrl_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  group;
        logic [7:0]  count;
        logic        status;
        logic [31:0] value;
    } t_frame;

    // controller -> datapath
    typedef struct packed {
        logic take;      // input transfer this cycle
        logic rsp_load;  // RAM read data valid, build value response
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic req_hit;   // current input is a REQUEST that finds its entry
    } t_dp_stat;

    // cumulative end index of group g; groups beyond the register read as 0
    function automatic logic [5:0] grp_end(input logic [35:0] ends, input logic [7:0] g);
        logic [5:0] e;
        case (g)
            8'd0:    e = ends[5:0];
            8'd1:    e = ends[11:6];
            8'd2:    e = ends[17:12];
            8'd3:    e = ends[23:18];
            8'd4:    e = ends[29:24];
            8'd5:    e = ends[35:30];
            default: e = 6'd0;
        endcase
        return e;
    endfunction

    function automatic logic [5:0] grp_start(input logic [35:0] ends, input logic [7:0] g);
        return (g == 8'd0) ? 6'd0 : grp_end(ends, g - 8'd1);
    endfunction

    function automatic logic [31:0] truncate_to(input logic [2:0] t, input logic [31:0] v);
        logic [31:0] r;
        case (t) inside
            TYPE_FLAG:         r = {31'd0, (v != 32'd0)};
            TYPE_U8, TYPE_S8:  r = {24'd0, v[7:0]};
            TYPE_U16, TYPE_S16: r = {16'd0, v[15:0]};
            default:           r = v;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] extend_from(input logic [2:0] t, input logic [31:0] v);
        logic [31:0] r;
        case (t)
            TYPE_FLAG: r = {31'd0, (v[7:0] != 8'd0)};
            TYPE_U8:   r = {24'd0, v[7:0]};
            TYPE_U16:  r = {16'd0, v[15:0]};
            TYPE_S8:   r = {{24{v[7]}}, v[7:0]};
            TYPE_S16:  r = {{16{v[15]}}, v[15:0]};
            default:   r = v;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

### hdl/cpae_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module cpae_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output      logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

### hdl/cpae_ctrl.sv
// Controller of the parameter access engine: handshakes and request sequencing.
// Depends on cpae_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cpae_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_mode,
    output      logic              o_in_ready,
    output      logic              o_out_valid,
    input  wire logic              i_out_ready,
    input  wire cpae_pkg::t_dp_stat i_stat,
    output      cpae_pkg::t_dp_cmd  o_cmd
);
    import cpae_pkg::*;

    t_ctrl_state r_state, n_state;
    logic        r_out_valid, n_out_valid;
    logic        w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        case (r_state)
            ST_IDLE: begin
                // a poll needs the output register free or emptying now
                o_in_ready = !r_out_valid || i_out_ready;
                if (w_take && i_stat.req_hit) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.rsp_load = 1'b1;
                n_state        = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
        o_cmd.take = w_take;

        if (w_take && i_in_mode) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign w_take      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

### hdl/cpae_dp.sv
// Datapath of the parameter access engine: config registers, lookup, link state,
// response frame, output register and the value store. Depends on cpae_pkg, cpae_ram.
`timescale 1ns / 1ps
`default_nettype none
module cpae_dp #(
    parameter int NUM_PARAMS = cpae_pkg::NUM_PARAMS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [cpae_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [cpae_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              i_mode,
    input  wire logic [7:0]                        i_command,
    input  wire logic [7:0]                        i_group,
    input  wire logic [7:0]                        i_pidx,
    input  wire logic [31:0]                       i_value,
    input  wire cpae_pkg::t_dp_cmd                 i_cmd,
    output      cpae_pkg::t_dp_stat                o_stat,
    output      cpae_pkg::t_frame                  o_out
);
    import cpae_pkg::*;

    localparam int AW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
    localparam logic [6:0] NP7 = 7'(NUM_PARAMS);

    // configuration
    logic [2:0]  r_group_count;
    logic [35:0] r_group_ends;
    logic [5:0]  r_param_total;
    logic [47:0] r_type_lo, r_type_hi;

    // engine state
    t_link       r_link, n_link;
    logic [2:0]  r_cursor, n_cursor;
    logic        r_clear, n_clear;
    t_frame      r_frame, n_frame;
    t_frame      r_out, n_out;
    logic [NUM_PARAMS-1:0] r_valid;

    // held request
    logic [7:0]  r_req_group, r_req_pidx;
    logic [2:0]  r_req_type;
    logic        r_req_valid;

    logic [2:0]  w_ngrp;
    logic [6:0]  w_tot;
    logic [5:0]  w_start, w_end;
    logic [8:0]  w_pos;
    logic        w_found;
    logic [IDX_W-1:0] w_idx;
    logic [AW-1:0]    w_addr;
    logic [2:0]  w_type;
    logic [2:0]  w_tarr [32];
    logic        w_we, w_re;
    logic [31:0] w_rdata;
    logic [2:0]  w_dsel, w_dnext;
    logic [7:0]  w_dsize;
    t_frame      w_f1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_count <= 3'd1;
            r_group_ends  <= '0;
            r_param_total <= '0;
            r_type_lo     <= '0;
            r_type_hi     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GROUP_COUNT: r_group_count <= i_cfg_data[2:0];
                CFG_GROUP_ENDS:  r_group_ends  <= i_cfg_data[35:0];
                CFG_PARAM_TOTAL: r_param_total <= i_cfg_data[5:0];
                CFG_TYPE_LO:     r_type_lo     <= i_cfg_data;
                CFG_TYPE_HI:     r_type_hi     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    for (genvar k = 0; k < 16; k++) begin : g_tmap
        assign w_tarr[k]      = r_type_lo[3*k +: 3];
        assign w_tarr[k + 16] = r_type_hi[3*k +: 3];
    end

    // effective group count and total
    assign w_ngrp = (r_group_count == 3'd0) ? 3'd1 :
                    (r_group_count > 3'(MAX_GROUPS)) ? 3'(MAX_GROUPS) : r_group_count;
    assign w_tot  = ({1'b0, r_param_total} > NP7) ? NP7 : {1'b0, r_param_total};

    // entry lookup for the incoming frame
    assign w_start = grp_start(r_group_ends, i_group);
    assign w_end   = grp_end(r_group_ends, i_group);
    assign w_pos   = {3'd0, w_start} + {1'b0, i_pidx};
    assign w_found = (i_group < {5'd0, w_ngrp}) && (w_pos < {3'd0, w_end})
                     && (w_pos < {2'd0, w_tot}) && (w_pos < {2'd0, NP7});
    assign w_idx   = w_pos[IDX_W-1:0];
    assign w_addr  = w_idx[AW-1:0];
    assign w_type  = w_idx[5] ? TYPE_RAW : w_tarr[w_idx[4:0]];

    assign o_stat.req_hit = !i_mode && (i_command == CMD_REQUEST)
                            && (r_link == LINK_READY) && w_found;

    assign w_we = i_cmd.take && !i_mode && (i_command == CMD_INJECT)
                  && (r_link == LINK_READY) && w_found;
    assign w_re = i_cmd.take && o_stat.req_hit;

    cpae_ram #(
        .WIDTH (32),
        .DEPTH (NUM_PARAMS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_addr),
        .i_wdata (truncate_to(w_type, i_value)),
        .i_re    (w_re),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    // diagnostic frame for the current cursor
    assign w_dsel  = (r_cursor >= w_ngrp) ? 3'd0 : r_cursor;
    assign w_dsize = {2'd0, grp_end(r_group_ends, {5'd0, w_dsel})}
                     - {2'd0, grp_start(r_group_ends, {5'd0, w_dsel})};
    assign w_dnext = w_dsel + 3'd1;
    assign w_f1    = r_clear ? t_frame'('0) : r_frame;

    always_comb begin
        n_link   = r_link;
        n_cursor = r_cursor;
        n_clear  = r_clear;
        n_frame  = r_frame;
        n_out    = r_out;
        if (i_cmd.rsp_load) begin
            n_frame.kind   = KIND_VALUE;
            n_frame.group  = r_req_group;
            n_frame.count  = r_req_pidx;
            n_frame.status = 1'b0;
            n_frame.value  = extend_from(r_req_type, r_req_valid ? w_rdata : 32'd0);
        end else if (i_cmd.take && !i_mode) begin
            if (i_command == CMD_INIT) begin
                n_link = LINK_DIAG;
            end else if (i_command == CMD_INJECT && r_link == LINK_READY) begin
                n_frame.kind   = KIND_ACK;
                n_frame.group  = i_group;
                n_frame.count  = i_pidx;
                n_frame.status = !w_found;
                n_frame.value  = 32'd0;
            end
        end else if (i_cmd.take && i_mode) begin
            // poll: drop a sent one-shot, then advance diagnostics or arm the clear
            n_frame = w_f1;
            n_clear = 1'b0;
            if (r_link == LINK_DIAG) begin
                n_frame.kind   = KIND_DIAG;
                n_frame.group  = {5'd0, w_dsel};
                n_frame.count  = w_dsize;
                n_frame.status = 1'b0;
                n_frame.value  = 32'd0;
                if (w_dnext >= w_ngrp) begin
                    n_cursor = 3'd0;
                    n_link   = LINK_READY;
                end else begin
                    n_cursor = w_dnext;
                end
            end else if (w_f1.kind != KIND_EMPTY) begin
                n_clear = 1'b1;
            end
            n_out = n_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link   <= LINK_DISC;
            r_cursor <= 3'd0;
            r_clear  <= 1'b0;
            r_frame  <= '0;
            r_valid  <= '0;
        end else begin
            r_link   <= n_link;
            r_cursor <= n_cursor;
            r_clear  <= n_clear;
            r_frame  <= n_frame;
            if (w_we) begin
                r_valid[w_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (w_re) begin
            r_req_group <= i_group;
            r_req_pidx  <= i_pidx;
            r_req_type  <= w_type;
            r_req_valid <= r_valid[w_addr];
        end
    end

    assign o_out = r_out;

endmodule
`default_nettype wire

### hdl/can_parameter_access_engine.sv
// Top level of the CAN parameter access engine: ports, field packing, controller
// and datapath. Depends on cpae_pkg, cpae_ctrl, cpae_dp (and cpae_ram below it).
`timescale 1ns / 1ps
`default_nettype none
// Each input transfer is either a received command frame (tuser = 0) or a poll
// for the response frame (tuser = 1). Command frames produce no output: INIT puts
// the link in diagnostic mode, INJECT (link ready) stores a value truncated to the
// entry's type if the entry is found and arms an acknowledge, REQUEST (link ready,
// entry found) arms a value response and is silent otherwise. Every poll produces
// exactly one output transfer holding the current response frame; in diagnostic
// mode each poll walks one group and reports its size, and the link turns ready
// after the last group. A sent acknowledge or value response is cleared on the
// following poll. A REQUEST that hits moves the controller to its read state,
// since the value store is a RAM with a registered read port, and no input is
// taken in that state. Any input transfer, command frame or poll, is taken only
// when the output register is empty or being drained in the same cycle, so a
// stalled output holds off the input side. The store is cleared at reset through
// per-entry valid bits, so there is no clearing pass and the block is ready right
// after reset. Configuration writes are only legal while the block is idle.
module can_parameter_access_engine #(
    parameter int NUM_PARAMS = cpae_pkg::NUM_PARAMS_DEF   // 8 to 64 entries
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration write port
    input  wire logic                            i_cfg_we,
    input  wire logic [cpae_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [cpae_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  wire logic                            s_axis_tvalid,
    output      logic                            s_axis_tready,
    // [7:0] command_byte, [15:8] group_id, [23:16] param_index, [55:24] inject_value
    input  wire logic [55:0]                     s_axis_tdata,
    // [0] mode
    input  wire logic                            s_axis_tuser,
    // output stream
    output      logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [7:0] resp_group, [15:8] resp_count_or_index, [16] resp_status,
    // [48:17] resp_value, [55:49] zero
    output      logic [55:0]                     m_axis_tdata,
    // [1:0] resp_kind
    output      logic [1:0]                      m_axis_tuser
);
    import cpae_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    t_frame   w_out;

    cpae_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_mode   (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    cpae_dp #(
        .NUM_PARAMS (NUM_PARAMS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_mode     (s_axis_tuser),
        .i_command  (s_axis_tdata[7:0]),
        .i_group    (s_axis_tdata[15:8]),
        .i_pidx     (s_axis_tdata[23:16]),
        .i_value    (s_axis_tdata[55:24]),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_out      (w_out)
    );

    assign m_axis_tdata = {7'd0, w_out.value, w_out.status, w_out.count, w_out.group};
    assign m_axis_tuser = w_out.kind;

endmodule
`default_nettype wire

### hdl/cpae_checker.sv
// Port-level checker for the CAN parameter access engine, bound to the top level.
// Depends on cpae_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module cpae_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic        s_axis_tuser,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [55:0] m_axis_tdata,
    input  wire logic [1:0]  m_axis_tuser
);
    import cpae_pkg::*;

    logic w_poll, w_frame;

    assign w_poll  = s_axis_tvalid && s_axis_tready && s_axis_tuser;
    assign w_frame = s_axis_tvalid && s_axis_tready && !s_axis_tuser;

    `ASSERT_CLK(a_rst_idle, i_clk, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")
    `ASSERT_CLK_RST(a_poll_out, i_clk, i_rst_n, w_poll |=> m_axis_tvalid, "poll gave no output")
    `ASSERT_CLK_RST(a_frame_quiet, i_clk, i_rst_n, (w_frame && !m_axis_tvalid) |=> !m_axis_tvalid, "command frame made output")
    `ASSERT_CLK_RST(a_empty_zero, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tuser == KIND_EMPTY) |-> (m_axis_tdata == 56'd0), "empty response with data")
    `ASSERT_CLK_RST(a_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled output changed")

endmodule

bind can_parameter_access_engine cpae_checker u_cpae_checker (.*);
`default_nettype wire
